[hdl/ckb_pkg.sv]
// Shared constants and types for the clipped colour-key blit.
package ckb_pkg;

    localparam int ADDR_BITS_DEF = 22;
    localparam int DIM_BITS_DEF  = 12;
    localparam int PIXEL_BITS    = 8;
    localparam int KEY_BITS      = 9;
    localparam int CFG_IDX_BITS  = 3;
    localparam int FIFO_DEPTH    = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_DST_ORIGIN  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DST_STRIDE  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DST_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_ORIGIN  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_STRIDE  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECT_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECT_HEIGHT = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_KEY_VALUE   = 3'd7;

    localparam int RST_DST_ORIGIN  = 0;
    localparam int RST_DST_STRIDE  = 640;
    localparam int RST_DST_LIMIT   = 307200;
    localparam int RST_SRC_ORIGIN  = 0;
    localparam int RST_SRC_STRIDE  = 640;
    localparam int RST_RECT_WIDTH  = 1;
    localparam int RST_RECT_HEIGHT = 1;
    localparam logic [KEY_BITS-1:0] RST_KEY_VALUE = 9'h1FF;

    typedef struct packed {
        logic pre_write;
        logic aborted;
        logic last;
    } ckb_flags_t;

    localparam int FLAGS_BITS = $bits(ckb_flags_t);

endpackage

[hdl/ckb_front.sv]
// Front end: accepts pixels, keeps raster counters and row bases, classifies each item.
module ckb_front #(
    parameter int ADDR_BITS = ckb_pkg::ADDR_BITS_DEF,
    parameter int DIM_BITS  = ckb_pkg::DIM_BITS_DEF,
    parameter int ITEM_BITS = 2 * ADDR_BITS + 1 + ckb_pkg::PIXEL_BITS + ckb_pkg::FLAGS_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ckb_pkg::PIXEL_BITS-1:0]  pixel_in,
    input  logic [ADDR_BITS-1:0]            dst_origin,
    input  logic [DIM_BITS-1:0]             dst_stride,
    input  logic [ADDR_BITS-1:0]            dst_limit,
    input  logic [ADDR_BITS-1:0]            src_origin,
    input  logic [DIM_BITS-1:0]             src_stride,
    input  logic [DIM_BITS-1:0]             rect_width,
    input  logic [DIM_BITS-1:0]             rect_height,
    output logic                            push_valid,
    input  logic                            push_ready,
    output logic [ITEM_BITS-1:0]            push_data
);

    localparam int SW = ((ADDR_BITS > DIM_BITS) ? ADDR_BITS : DIM_BITS) + 2;

    logic [DIM_BITS-1:0]        col_reg, col_next;
    logic [DIM_BITS-1:0]        row_reg, row_next;
    logic signed [ADDR_BITS:0]  dbase_reg, dbase_next;
    logic [ADDR_BITS-1:0]       sbase_reg, sbase_next;
    logic                       stop_reg, stop_next;

    logic                       start;
    logic                       accept;
    logic signed [ADDR_BITS:0]  cur_dbase;
    logic [ADDR_BITS-1:0]       cur_sbase;
    logic                       cur_stop;
    logic signed [SW-1:0]       dsum;
    logic signed [SW-1:0]       lim_ext;
    logic [SW-1:0]              ssum;
    logic signed [SW-1:0]       nbase;
    logic signed [SW-1:0]       dmax;
    logic [SW-1:0]              nsrc;
    logic                       hit;
    logic                       stop;
    logic                       row_end;
    logic                       last;
    ckb_pkg::ckb_flags_t        flags;

    assign start     = (col_reg == '0) && (row_reg == '0);
    assign accept    = in_valid && in_ready;
    assign cur_dbase = start ? {dst_origin[ADDR_BITS-1], dst_origin} : dbase_reg;
    assign cur_sbase = start ? src_origin : sbase_reg;
    assign cur_stop  = start ? 1'b0 : stop_reg;

    assign dsum    = {{(SW-ADDR_BITS-1){cur_dbase[ADDR_BITS]}}, cur_dbase}
                   + {{(SW-DIM_BITS){1'b0}}, col_reg};
    assign lim_ext = {{(SW-ADDR_BITS){1'b0}}, dst_limit};
    assign hit     = dsum >= lim_ext;
    assign stop    = cur_stop || hit;
    assign ssum    = {{(SW-ADDR_BITS){1'b0}}, cur_sbase} + {{(SW-DIM_BITS){1'b0}}, col_reg};

    assign row_end = ({1'b0, col_reg} + 1'b1) >= {1'b0, rect_width};
    assign last    = row_end && (({1'b0, row_reg} + 1'b1) >= {1'b0, rect_height});

    assign nbase = {{(SW-ADDR_BITS-1){cur_dbase[ADDR_BITS]}}, cur_dbase}
                 + {{(SW-DIM_BITS){1'b0}}, dst_stride};
    assign dmax  = {{(SW-ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};
    assign nsrc  = {{(SW-ADDR_BITS){1'b0}}, cur_sbase} + {{(SW-DIM_BITS){1'b0}}, src_stride};

    assign flags.pre_write = !stop && !cur_dbase[ADDR_BITS];
    assign flags.aborted   = stop;
    assign flags.last      = last;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push_data  = {dsum[ADDR_BITS:0], ssum[ADDR_BITS-1:0], pixel_in, flags};

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        dbase_next = dbase_reg;
        sbase_next = sbase_reg;
        stop_next  = stop_reg;
        if (accept)
        begin
            priority if (last)
            begin
                col_next   = '0;
                row_next   = '0;
                stop_next  = 1'b0;
                dbase_next = {dst_origin[ADDR_BITS-1], dst_origin};
                sbase_next = src_origin;
            end
            else if (row_end)
            begin
                col_next   = '0;
                row_next   = row_reg + 1'b1;
                stop_next  = stop;
                dbase_next = (nbase > dmax) ? dmax[ADDR_BITS:0] : nbase[ADDR_BITS:0];
                sbase_next = nsrc[ADDR_BITS-1:0];
            end
            else
            begin
                col_next   = col_reg + 1'b1;
                stop_next  = stop;
                dbase_next = cur_dbase;
                sbase_next = cur_sbase;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            dbase_reg <= '0;
            sbase_reg <= '0;
            stop_reg  <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            dbase_reg <= dbase_next;
            sbase_reg <= sbase_next;
            stop_reg  <= stop_next;
        end
    end

`ifndef SYNTHESIS
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> (col_reg == '0) && (row_reg == '0) && !stop_reg)
        else $error("counters not restarted after final pixel");

    a_hit_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && hit && !last |=> stop_reg)
        else $error("limit hit not held for rest of rectangle");
`endif

endmodule

[hdl/ckb_fifo.sv]
// Two-entry queue between the front end and the output stage.
module ckb_fifo #(
    parameter int ITEM_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  logic [ITEM_BITS-1:0] push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output logic [ITEM_BITS-1:0] pop_data
);

    localparam int PTR_BITS = $clog2(ckb_pkg::FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(ckb_pkg::FIFO_DEPTH + 1);

    logic [ITEM_BITS-1:0] mem [ckb_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 push;
    logic                 pop;

    assign push_ready = count_reg != CNT_BITS'(ckb_pkg::FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(ckb_pkg::FIFO_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(ckb_pkg::FIFO_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        !pop_valid |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty but pointers differ");
`endif

endmodule

[hdl/ckb_back.sv]
// Output stage: applies the colour key and holds the result item for the receiver.
module ckb_back #(
    parameter int ADDR_BITS = ckb_pkg::ADDR_BITS_DEF,
    parameter int ITEM_BITS = 2 * ADDR_BITS + 1 + ckb_pkg::PIXEL_BITS + ckb_pkg::FLAGS_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  logic [ITEM_BITS-1:0]               pop_data,
    input  logic [ckb_pkg::KEY_BITS-1:0]       key_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ADDR_BITS:0]          dst_address,
    output logic [ADDR_BITS-1:0]               src_address,
    output logic [ckb_pkg::PIXEL_BITS-1:0]     pixel_out,
    output logic                               write_enable,
    output logic                               aborted,
    output logic                               last_pixel
);

    logic [ADDR_BITS:0]             q_dst;
    logic [ADDR_BITS-1:0]           q_src;
    logic [ckb_pkg::PIXEL_BITS-1:0] q_pix;
    ckb_pkg::ckb_flags_t            q_flags;
    logic                           key_hit;
    logic                           load;

    logic                           out_valid_reg;
    logic [ADDR_BITS:0]             dst_reg;
    logic [ADDR_BITS-1:0]           src_reg;
    logic [ckb_pkg::PIXEL_BITS-1:0] pix_reg;
    logic                           we_reg;
    logic                           aborted_reg;
    logic                           last_reg;

    assign {q_dst, q_src, q_pix, q_flags} = pop_data;
    assign key_hit   = !key_value[ckb_pkg::KEY_BITS-1]
                    && (key_value[ckb_pkg::PIXEL_BITS-1:0] == q_pix);
    assign pop_ready = !out_valid_reg || out_ready;
    assign load      = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            out_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dst_reg     <= q_dst;
            src_reg     <= q_src;
            pix_reg     <= q_pix;
            we_reg      <= q_flags.pre_write && !key_hit;
            aborted_reg <= q_flags.aborted;
            last_reg    <= q_flags.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dst_address  = $signed(dst_reg);
    assign src_address  = src_reg;
    assign pixel_out    = pix_reg;
    assign write_enable = we_reg;
    assign aborted      = aborted_reg;
    assign last_pixel   = last_reg;

`ifndef SYNTHESIS
    a_no_write_aborted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(we_reg && aborted_reg))
        else $error("write enabled on an aborted item");
`endif

endmodule

[hdl/clipped_color_key_blit.sv]
// Top level of the clipped colour-key rectangle blit address and enable generator.
//
// Source pixels of a rectangle enter on in_valid/in_ready in raster order; for each
// item one result leaves on out_valid/out_ready carrying the destination and source
// offsets, the pixel, its write enable, an abort flag and a last-pixel mark.
// Registers are written on cfg_valid/cfg_ready (always ready) with cfg_index and
// cfg_data; write them only while no item is in flight. Origins are taken at the
// first pixel of each rectangle.
// An accepted item is written into the queue and then loaded into the output
// register, from which the receiver takes it.
// Throughput: one item per cycle while the queue has room; the front end's counter
// update and the destination add-and-compare against the limit form the per-item step.
// A two-entry queue and the output register separate input and output, so the
// input keeps flowing until the queue fills while out_ready is low, then stalls.
// Reset clears counters, queue and output valid and loads register defaults.
module clipped_color_key_blit #(
    parameter int ADDR_BITS = ckb_pkg::ADDR_BITS_DEF,
    parameter int DIM_BITS  = ckb_pkg::DIM_BITS_DEF,
    parameter int CFG_BITS  = (ADDR_BITS > DIM_BITS) ? ADDR_BITS : DIM_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ckb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]               cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ckb_pkg::PIXEL_BITS-1:0]    pixel_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [ADDR_BITS:0]         dst_address,
    output logic [ADDR_BITS-1:0]              src_address,
    output logic [ckb_pkg::PIXEL_BITS-1:0]    pixel_out,
    output logic                              write_enable,
    output logic                              aborted,
    output logic                              last_pixel
);

    localparam int ITEM_BITS = 2 * ADDR_BITS + 1 + ckb_pkg::PIXEL_BITS + ckb_pkg::FLAGS_BITS;

    logic [ADDR_BITS-1:0]          dst_origin_reg;
    logic [DIM_BITS-1:0]           dst_stride_reg;
    logic [ADDR_BITS-1:0]          dst_limit_reg;
    logic [ADDR_BITS-1:0]          src_origin_reg;
    logic [DIM_BITS-1:0]           src_stride_reg;
    logic [DIM_BITS-1:0]           rect_width_reg;
    logic [DIM_BITS-1:0]           rect_height_reg;
    logic [ckb_pkg::KEY_BITS-1:0]  key_value_reg;

    logic                          push_valid;
    logic                          push_ready;
    logic [ITEM_BITS-1:0]          push_data;
    logic                          pop_valid;
    logic                          pop_ready;
    logic [ITEM_BITS-1:0]          pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_origin_reg  <= ADDR_BITS'(ckb_pkg::RST_DST_ORIGIN);
            dst_stride_reg  <= DIM_BITS'(ckb_pkg::RST_DST_STRIDE);
            dst_limit_reg   <= ADDR_BITS'(ckb_pkg::RST_DST_LIMIT);
            src_origin_reg  <= ADDR_BITS'(ckb_pkg::RST_SRC_ORIGIN);
            src_stride_reg  <= DIM_BITS'(ckb_pkg::RST_SRC_STRIDE);
            rect_width_reg  <= DIM_BITS'(ckb_pkg::RST_RECT_WIDTH);
            rect_height_reg <= DIM_BITS'(ckb_pkg::RST_RECT_HEIGHT);
            key_value_reg   <= ckb_pkg::RST_KEY_VALUE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ckb_pkg::REG_DST_ORIGIN:  dst_origin_reg  <= cfg_data[ADDR_BITS-1:0];
                ckb_pkg::REG_DST_STRIDE:  dst_stride_reg  <= cfg_data[DIM_BITS-1:0];
                ckb_pkg::REG_DST_LIMIT:   dst_limit_reg   <= cfg_data[ADDR_BITS-1:0];
                ckb_pkg::REG_SRC_ORIGIN:  src_origin_reg  <= cfg_data[ADDR_BITS-1:0];
                ckb_pkg::REG_SRC_STRIDE:  src_stride_reg  <= cfg_data[DIM_BITS-1:0];
                ckb_pkg::REG_RECT_WIDTH:  rect_width_reg  <= cfg_data[DIM_BITS-1:0];
                ckb_pkg::REG_RECT_HEIGHT: rect_height_reg <= cfg_data[DIM_BITS-1:0];
                ckb_pkg::REG_KEY_VALUE:   key_value_reg   <= cfg_data[ckb_pkg::KEY_BITS-1:0];
                default:                  key_value_reg   <= key_value_reg;
            endcase
        end
    end

    ckb_front #(
        .ADDR_BITS (ADDR_BITS),
        .DIM_BITS  (DIM_BITS),
        .ITEM_BITS (ITEM_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_in    (pixel_in),
        .dst_origin  (dst_origin_reg),
        .dst_stride  (dst_stride_reg),
        .dst_limit   (dst_limit_reg),
        .src_origin  (src_origin_reg),
        .src_stride  (src_stride_reg),
        .rect_width  (rect_width_reg),
        .rect_height (rect_height_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    ckb_fifo #(
        .ITEM_BITS (ITEM_BITS)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ckb_back #(
        .ADDR_BITS (ADDR_BITS),
        .ITEM_BITS (ITEM_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .key_value    (key_value_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dst_address  (dst_address),
        .src_address  (src_address),
        .pixel_out    (pixel_out),
        .write_enable (write_enable),
        .aborted      (aborted),
        .last_pixel   (last_pixel)
    );

endmodule

[sim/clipped_color_key_blit_tb.sv]
// Self-checking testbench for the clipped colour-key blit: predicted results per pixel item.
module clipped_color_key_blit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ckb_pkg::*;

    localparam int AW = ADDR_BITS_DEF;
    localparam int DW = DIM_BITS_DEF;
    localparam int CW = (AW > DW) ? AW : DW;
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 1450;
    localparam longint DST_BASE_MAX = (longint'(1) <<< AW) - 1;

    typedef struct packed {
        logic signed [AW:0]      dst_address;
        logic [AW-1:0]           src_address;
        logic [PIXEL_BITS-1:0]   pixel;
        logic                    write_enable;
        logic                    aborted;
        logic                    last_pixel;
    } blit_out_t;

    class pixel_scoreboard;
        logic signed [AW-1:0]       dst_origin;
        logic [DW-1:0]              dst_stride;
        logic [AW-1:0]              dst_limit;
        logic [AW-1:0]              src_origin;
        logic [DW-1:0]              src_stride;
        logic [DW-1:0]              rect_width;
        logic [DW-1:0]              rect_height;
        logic signed [KEY_BITS-1:0] key_value;
        logic [DW-1:0]              column_cnt;
        logic [DW-1:0]              row_cnt;
        longint                     dst_base;
        logic [AW-1:0]              src_base;
        bit                         stopped;
        blit_out_t                  expected_out[$];
        int                         failures;

        function new();
            dst_origin  = AW'(RST_DST_ORIGIN);
            dst_stride  = DW'(RST_DST_STRIDE);
            dst_limit   = AW'(RST_DST_LIMIT);
            src_origin  = AW'(RST_SRC_ORIGIN);
            src_stride  = DW'(RST_SRC_STRIDE);
            rect_width  = DW'(RST_RECT_WIDTH);
            rect_height = DW'(RST_RECT_HEIGHT);
            key_value   = RST_KEY_VALUE;
            column_cnt  = '0;
            row_cnt     = '0;
            dst_base    = 0;
            src_base    = '0;
            stopped     = 1'b0;
            failures    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CW-1:0] data);
            case (idx)
                REG_DST_ORIGIN:  dst_origin  = data[AW-1:0];
                REG_DST_STRIDE:  dst_stride  = data[DW-1:0];
                REG_DST_LIMIT:   dst_limit   = data[AW-1:0];
                REG_SRC_ORIGIN:  src_origin  = data[AW-1:0];
                REG_SRC_STRIDE:  src_stride  = data[DW-1:0];
                REG_RECT_WIDTH:  rect_width  = data[DW-1:0];
                REG_RECT_HEIGHT: rect_height = data[DW-1:0];
                REG_KEY_VALUE:   key_value   = data[KEY_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIXEL_BITS-1:0] pix);
            longint    dst;
            bit        row_end;
            bit        last_px;
            bit        we;
            blit_out_t r;
            if (column_cnt == '0 && row_cnt == '0) begin
                dst_base = longint'(dst_origin);
                src_base = src_origin;
                stopped  = 1'b0;
            end
            dst = dst_base + longint'(column_cnt);
            if (dst >= longint'(dst_limit))
                stopped = 1'b1;
            we = !stopped && dst_base >= 0 && int'(pix) != int'(key_value);
            row_end = int'(column_cnt) + 1 >= int'(rect_width);
            last_px = row_end && (int'(row_cnt) + 1 >= int'(rect_height));
            r.dst_address  = dst[AW:0];
            r.src_address  = src_base + AW'(column_cnt);
            r.pixel        = pix;
            r.write_enable = we;
            r.aborted      = stopped;
            r.last_pixel   = last_px;
            expected_out = {expected_out, r};
            if (last_px) begin
                column_cnt = '0;
                row_cnt    = '0;
                stopped    = 1'b0;
                dst_base   = longint'(dst_origin);
                src_base   = src_origin;
            end
            else if (row_end) begin
                column_cnt = '0;
                row_cnt    = row_cnt + 1'b1;
                dst_base   = dst_base + longint'(dst_stride);
                if (dst_base > DST_BASE_MAX)
                    dst_base = DST_BASE_MAX;
                src_base   = src_base + AW'(src_stride);
            end
            else begin
                column_cnt = column_cnt + 1'b1;
            end
        endfunction

        function void field_check(string name, logic [AW:0] want, logic [AW:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_pixel(blit_out_t got);
            blit_out_t want;
            if (expected_out.size() == 0) begin
                $error("result with nothing expected: dst_address 0x%0h", got.dst_address);
                failures++;
                return;
            end
            want = expected_out.pop_front();
            field_check("dst_address", want.dst_address, got.dst_address);
            field_check("src_address", (AW+1)'(want.src_address), (AW+1)'(got.src_address));
            field_check("pixel_out", (AW+1)'(want.pixel), (AW+1)'(got.pixel));
            field_check("write_enable", (AW+1)'(want.write_enable), (AW+1)'(got.write_enable));
            field_check("aborted", (AW+1)'(want.aborted), (AW+1)'(got.aborted));
            field_check("last_pixel", (AW+1)'(want.last_pixel), (AW+1)'(got.last_pixel));
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CW-1:0]            cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [PIXEL_BITS-1:0]    pixel_in = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [AW:0]       dst_address;
    logic [AW-1:0]            src_address;
    logic [PIXEL_BITS-1:0]    pixel_out;
    logic                     write_enable;
    logic                     aborted;
    logic                     last_pixel;

    pixel_scoreboard board;
    bit quiet_run = 1'b0;

    clipped_color_key_blit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_in     (pixel_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dst_address  (dst_address),
        .src_address  (src_address),
        .pixel_out    (pixel_out),
        .write_enable (write_enable),
        .aborted      (aborted),
        .last_pixel   (last_pixel)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            board.write_reg(cfg_index, cfg_data);
        if (rst_n && in_valid && in_ready)
            board.note_pixel(pixel_in);
        if (rst_n && out_valid && out_ready)
            board.check_pixel({dst_address, src_address, pixel_out,
                               write_enable, aborted, last_pixel});
    end

    always @(posedge clk)
    begin
        out_ready <= quiet_run ? 1'b1 : ($urandom_range(0, 99) >= 30);
    end

    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("clipped_color_key_blit_tb failed");
        $finish;
    end

    task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, int v);
        cfg_index <= idx;
        cfg_data  <= v[CW-1:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic send_pixel(logic [PIXEL_BITS-1:0] pix);
        if (!quiet_run && $urandom_range(0, 99) < 30) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 30);
        end
        in_valid <= 1'b1;
        pixel_in <= pix;
        do @(posedge clk); while (!in_ready);
    endtask

    // hold until every expected item has left the block
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.expected_out.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic int pick(int lo, int hi, int tlo, int thi);
        int sel;
        sel = int'($urandom_range(0, 5));
        case (sel)
            0:       return lo;
            1:       return hi;
            2, 3:    return tlo + int'($urandom_range(0, thi - tlo));
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    task automatic random_setting();
        logic [CFG_IDX_BITS-1:0] idx;
        int v;
        for (int r = 0; r < 8; r++)
        begin
            idx = r[CFG_IDX_BITS-1:0];
            case (idx)
                REG_DST_ORIGIN:  v = pick(-2097152, 2097151, -40, 300);
                REG_DST_STRIDE:  v = pick(1, 4095, 1, 64);
                REG_DST_LIMIT:   v = pick(1, 4194303, 1, 400);
                REG_SRC_ORIGIN:  v = pick(0, 4194303, 4194200, 4194303);
                REG_SRC_STRIDE:  v = pick(1, 4095, 1, 64);
                REG_RECT_WIDTH:  v = pick(1, 4095, 1, 8);
                REG_RECT_HEIGHT: v = pick(1, 4095, 1, 6);
                default:         v = pick(-1, 255, -1, -1);
            endcase
            if ($urandom_range(0, 9) < 7)
                set_reg(idx, v);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [PIXEL_BITS-1:0] pat_a [12];
        logic [PIXEL_BITS-1:0] pat_c [6];
        logic [PIXEL_BITS-1:0] pix;
        int sent;
        int n;
        int phase;
        int area;
        pat_a = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h00, 8'h01,
                  8'h80, 8'h00, 8'hFE, 8'h0F, 8'hF0, 8'h00};
        pat_c = '{8'h80, 8'h7F, 8'h80, 8'h00, 8'h80, 8'hFF};
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: single-pixel plain copy
        send_pixel(8'h00);
        send_pixel(8'hFF);
        settle();

        // key zero, source wrap, abort part-way through a row
        set_reg(REG_DST_ORIGIN, 5);
        set_reg(REG_DST_STRIDE, 8);
        set_reg(REG_DST_LIMIT, 16);
        set_reg(REG_SRC_ORIGIN, 4194300);
        set_reg(REG_SRC_STRIDE, 4095);
        set_reg(REG_RECT_WIDTH, 4);
        set_reg(REG_RECT_HEIGHT, 3);
        set_reg(REG_KEY_VALUE, 0);
        cfg_valid <= 1'b0;
        foreach (pat_a[i])
            send_pixel(pat_a[i]);
        settle();

        // rows before the surface start: never written
        set_reg(REG_DST_ORIGIN, -2097152);
        set_reg(REG_DST_STRIDE, 4095);
        set_reg(REG_DST_LIMIT, 4194303);
        set_reg(REG_SRC_ORIGIN, 0);
        set_reg(REG_SRC_STRIDE, 1);
        set_reg(REG_RECT_WIDTH, 2);
        set_reg(REG_RECT_HEIGHT, 2);
        set_reg(REG_KEY_VALUE, 255);
        cfg_valid <= 1'b0;
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h80);
        settle();

        // limit of one: abort clears on the next rectangle
        set_reg(REG_DST_ORIGIN, 0);
        set_reg(REG_DST_LIMIT, 1);
        set_reg(REG_RECT_WIDTH, 3);
        set_reg(REG_RECT_HEIGHT, 1);
        set_reg(REG_KEY_VALUE, 128);
        cfg_valid <= 1'b0;
        foreach (pat_c[i])
            send_pixel(pat_c[i]);
        settle();

        // destination row base runs into saturation
        quiet_run = 1'b1;
        set_reg(REG_DST_ORIGIN, 2097151);
        set_reg(REG_DST_LIMIT, 4194303);
        set_reg(REG_RECT_WIDTH, 1);
        set_reg(REG_RECT_HEIGHT, 4095);
        set_reg(REG_KEY_VALUE, -1);
        cfg_valid <= 1'b0;
        sent = 0;
        for (int i = 0; i < 520; i++)
        begin
            send_pixel(8'($urandom_range(0, 255)));
            sent++;
        end
        settle();
        quiet_run = 1'b0;

        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            random_setting();
            quiet_run = (phase >= 6 && phase < 10);
            area = int'(board.rect_width) * int'(board.rect_height);
            if ($urandom_range(0, 4) != 0 && area <= 64)
                n = area * int'($urandom_range(1, 3));
            else
                n = int'($urandom_range(1, 60));
            for (int i = 0; i < n; i++)
            begin
                if (board.key_value >= 0 && $urandom_range(0, 9) < 4)
                    pix = board.key_value[PIXEL_BITS-1:0];
                else
                    pix = 8'($urandom_range(0, 255));
                send_pixel(pix);
                sent++;
            end
            settle();
            phase++;
        end
        quiet_run = 1'b0;

        if (board.failures == 0 && board.expected_out.size() == 0)
            $display("clipped_color_key_blit_tb passed");
        else
            $display("clipped_color_key_blit_tb failed");
        $finish;
    end

endmodule

[sim.f]
hdl/ckb_pkg.sv
hdl/ckb_front.sv
hdl/ckb_fifo.sv
hdl/ckb_back.sv
hdl/clipped_color_key_blit.sv
sim/clipped_color_key_blit_tb.sv
